// File: rtl/scc_pkg.sv
// Shared widths, request and register codes, and the result record for the
// single-class co-occurrence count unit. No dependencies.
`default_nettype none

package scc_pkg;

	// Parameter defaults
	localparam int MAX_SIDE_DEF     = 256;
	localparam int CLASS_VALUES_DEF = 256;

	// Fixed field widths
	localparam int CLASS_W    = 8;
	localparam int PIX_W      = CLASS_W + 1;   // missing flag over class
	localparam int SIZE_W     = 9;
	localparam int COUNT_W    = 20;
	localparam int DISTINCT_W = 9;
	localparam int REQ_W      = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;

	localparam logic [COUNT_W-1:0]    COUNT_MAX    = '1;
	localparam logic [DISTINCT_W-1:0] DISTINCT_MAX = '1;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_LOAD = 2'd0;
	localparam logic [REQ_W-1:0] REQ_PASS = 2'd1;
	localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FOCAL = 3'd3;

	// Reply kinds
	localparam logic REPLY_PASS = 1'b0;
	localparam logic REPLY_READ = 1'b1;

	typedef struct packed {
		logic                  valid;
		logic                  kind;
		logic [DISTINCT_W-1:0] distinct;
		logic                  present;
		logic [COUNT_W-1:0]    count;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/scc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module scc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/scc_seq.sv
// Count-pass and read sequencer: walks the pixel store, drives the per-class
// table RAM ports and forms result transactions. Depends on scc_pkg.
`default_nettype none

module scc_seq import scc_pkg::*; #(
	parameter int MAX_SIDE     = MAX_SIDE_DEF,
	parameter int CLASS_VALUES = CLASS_VALUES_DEF,
	localparam int SW = $clog2(MAX_SIDE + 1),
	localparam int AW = $clog2(MAX_SIDE * MAX_SIDE),
	localparam int CW = $clog2(CLASS_VALUES),
	localparam int EW = COUNT_W + 1
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               go_pass,
	input  wire logic               go_read,
	input  wire logic [CLASS_W-1:0] query_class,
	input  wire logic [SW-1:0]      cols_eff,
	input  wire logic [SW-1:0]      rows_eff,
	input  wire logic               mode,
	input  wire logic [CLASS_W-1:0] focal,
	output logic      [AW-1:0]      px_raddr,
	input  wire logic [PIX_W-1:0]   px_rdata,
	output logic      [CW-1:0]      cnt_raddr,
	input  wire logic [EW-1:0]      cnt_rdata,
	output logic                    cnt_we,
	output logic      [CW-1:0]      cnt_waddr,
	output logic      [EW-1:0]      cnt_wdata,
	output logic                    busy,
	output result_t                 res
);

	typedef enum logic [10:0] {
		S_IDLE    = 11'b000_0000_0001,
		S_RD_WAIT = 11'b000_0000_0010,
		S_CLEAR   = 11'b000_0000_0100,
		S_PX_RD   = 11'b000_0000_1000,
		S_PX_CHK  = 11'b000_0001_0000,
		S_SEEN_WR = 11'b000_0010_0000,
		S_NB_ADDR = 11'b000_0100_0000,
		S_NB_RD   = 11'b000_1000_0000,
		S_NB_CHK  = 11'b001_0000_0000,
		S_NB_WR   = 11'b010_0000_0000,
		S_DONE    = 11'b100_0000_0000
	} state_t;

	typedef enum logic [1:0] {
		STEP_ZERO = 2'd0,
		STEP_DEC  = 2'd1,
		STEP_INC  = 2'd2
	} step_t;

	// neighbor offsets: rook neighbors first, then the diagonals
	localparam step_t NB_DC [8] = '{STEP_ZERO, STEP_DEC, STEP_INC, STEP_ZERO,
	                                STEP_DEC, STEP_INC, STEP_DEC, STEP_INC};
	localparam step_t NB_DR [8] = '{STEP_DEC, STEP_ZERO, STEP_ZERO, STEP_INC,
	                                STEP_DEC, STEP_DEC, STEP_INC, STEP_INC};
	localparam logic [2:0] NB_LAST_ROOK  = 3'd3;
	localparam logic [2:0] NB_LAST_QUEEN = 3'd7;
	localparam logic [CW-1:0] CLR_LAST = CW'(CLASS_VALUES - 1);

	state_t state_q, state_d;

	logic [AW-1:0]         idx_q;
	logic [SW-1:0]         r_q, c_q;
	logic [CW-1:0]         clr_q;
	logic [2:0]            h_q;
	logic [CLASS_W-1:0]    cls_q, ncls_q;
	logic [AW-1:0]         nb_addr_q;
	logic                  query_ok_q;
	logic                  pass_done_q;
	logic [DISTINCT_W-1:0] distinct_q;
	logic                  res_valid_q;
	logic                  res_kind_q;
	logic [DISTINCT_W-1:0] res_distinct_q;
	logic                  res_present_q;
	logic [COUNT_W-1:0]    res_count_q;

	logic               px_usable;
	logic               px_last;
	logic               step_px;
	logic               next_h;
	logic [2:0]         h_last;
	logic [SW-1:0]      rows_m1, cols_m1;
	logic               nb_ok;
	logic [AW-1:0]      off_c, off_r, nb_addr, rows_ext;
	logic               cnt_seen;
	logic [COUNT_W-1:0] cnt_count, cnt_inc;

	// pixel and table word decode
	assign px_usable = !px_rdata[PIX_W-1] &&
	                   (32'(px_rdata[CLASS_W-1:0]) < CLASS_VALUES);
	assign cnt_seen  = cnt_rdata[COUNT_W];
	assign cnt_count = cnt_rdata[COUNT_W-1:0];
	assign cnt_inc   = (cnt_count == COUNT_MAX) ? cnt_count : cnt_count + 1'b1;

	// scan position
	assign rows_m1 = rows_eff - SW'(1);
	assign cols_m1 = cols_eff - SW'(1);
	assign px_last = (r_q == rows_m1) && (c_q == cols_m1);
	assign h_last  = mode ? NB_LAST_QUEEN : NB_LAST_ROOK;

	// neighbor bounds and address: idx +/- rows +/- 1
	assign rows_ext = AW'(rows_eff);
	always_comb begin
		nb_ok = 1'b1;
		case (NB_DC[h_q])
			STEP_DEC: begin
				nb_ok = (c_q != '0);
				off_c = '0 - rows_ext;
			end
			STEP_INC: begin
				nb_ok = (c_q != cols_m1);
				off_c = rows_ext;
			end
			default: begin
				off_c = '0;
			end
		endcase
		case (NB_DR[h_q])
			STEP_DEC: begin
				nb_ok = nb_ok && (r_q != '0);
				off_r = '1;
			end
			STEP_INC: begin
				nb_ok = nb_ok && (r_q != rows_m1);
				off_r = AW'(1);
			end
			default: begin
				off_r = '0;
			end
		endcase
		nb_addr = idx_q + off_c + off_r;
	end

	// sequencer and RAM port control
	always_comb begin
		state_d   = state_q;
		step_px   = 1'b0;
		next_h    = 1'b0;
		cnt_we    = 1'b0;
		cnt_waddr = CW'(cls_q);
		cnt_wdata = '0;
		cnt_raddr = CW'(query_class);
		px_raddr  = idx_q;
		case (state_q)
			S_IDLE: begin
				if (go_pass) begin
					state_d = S_CLEAR;
				end else if (go_read) begin
					state_d = S_RD_WAIT;
				end
			end
			S_RD_WAIT: begin
				state_d = S_IDLE;
			end
			S_CLEAR: begin
				cnt_we    = 1'b1;
				cnt_waddr = clr_q;
				if (clr_q == CLR_LAST) begin
					state_d = S_PX_RD;
				end
			end
			S_PX_RD: begin
				state_d = S_PX_CHK;
			end
			S_PX_CHK: begin
				cnt_raddr = CW'(px_rdata[CLASS_W-1:0]);
				if (px_usable) begin
					state_d = S_SEEN_WR;
				end else begin
					step_px = 1'b1;
				end
			end
			S_SEEN_WR: begin
				if (!cnt_seen) begin
					cnt_we    = 1'b1;
					cnt_wdata = {1'b1, cnt_count};
				end
				if (cls_q == focal) begin
					state_d = S_NB_ADDR;
				end else begin
					step_px = 1'b1;
				end
			end
			S_NB_ADDR: begin
				if (nb_ok) begin
					state_d = S_NB_RD;
				end else begin
					next_h = 1'b1;
				end
			end
			S_NB_RD: begin
				px_raddr = nb_addr_q;
				state_d  = S_NB_CHK;
			end
			S_NB_CHK: begin
				cnt_raddr = CW'(px_rdata[CLASS_W-1:0]);
				if (px_usable) begin
					state_d = S_NB_WR;
				end else begin
					next_h = 1'b1;
				end
			end
			S_NB_WR: begin
				cnt_we    = 1'b1;
				cnt_waddr = CW'(ncls_q);
				cnt_wdata = {cnt_seen, cnt_inc};
				next_h    = 1'b1;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (next_h) begin
			if (h_q == h_last) begin
				step_px = 1'b1;
			end else begin
				state_d = S_NB_ADDR;
			end
		end
		if (step_px) begin
			state_d = px_last ? S_DONE : S_PX_RD;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pass_done_q <= 1'b0;
			distinct_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_valid_q <= (state_q == S_RD_WAIT) || (state_q == S_DONE);
			if (state_q == S_IDLE && go_pass) begin
				distinct_q <= '0;
			end
			if (state_q == S_SEEN_WR && !cnt_seen && distinct_q != DISTINCT_MAX) begin
				distinct_q <= distinct_q + 1'b1;
			end
			if (state_q == S_DONE) begin
				pass_done_q <= 1'b1;
			end
		end
	end

	// scan counters and captured values
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && go_pass) begin
			idx_q <= '0;
			r_q   <= '0;
			c_q   <= '0;
			clr_q <= '0;
		end
		if (state_q == S_IDLE && go_read) begin
			query_ok_q <= (32'(query_class) < CLASS_VALUES);
		end
		if (state_q == S_CLEAR) begin
			clr_q <= clr_q + 1'b1;
		end
		if (state_q == S_PX_CHK) begin
			cls_q <= px_rdata[CLASS_W-1:0];
		end
		if (state_q == S_NB_CHK) begin
			ncls_q <= px_rdata[CLASS_W-1:0];
		end
		if (state_q == S_NB_ADDR) begin
			nb_addr_q <= nb_addr;
		end
		if (state_q == S_SEEN_WR) begin
			h_q <= '0;
		end else if (next_h) begin
			h_q <= h_q + 1'b1;
		end
		if (step_px) begin
			idx_q <= idx_q + 1'b1;
			if (r_q == rows_m1) begin
				r_q <= '0;
				c_q <= c_q + 1'b1;
			end else begin
				r_q <= r_q + 1'b1;
			end
		end
	end

	// result transaction payload
	always_ff @(posedge clk) begin
		if (state_q == S_RD_WAIT) begin
			res_kind_q     <= REPLY_READ;
			res_distinct_q <= distinct_q;
			if (query_ok_q && pass_done_q) begin
				res_present_q <= cnt_seen;
				res_count_q   <= cnt_count;
			end else begin
				res_present_q <= 1'b0;
				res_count_q   <= '0;
			end
		end else if (state_q == S_DONE) begin
			res_kind_q     <= REPLY_PASS;
			res_distinct_q <= distinct_q;
			res_present_q  <= 1'b0;
			res_count_q    <= '0;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		res.valid    = res_valid_q;
		res.kind     = res_kind_q;
		res.distinct = res_distinct_q;
		res.present  = res_present_q;
		res.count    = res_count_q;
	end

endmodule

`default_nettype wire

// File: rtl/single_class_cooccurrence_count_unit.sv
// Top level of the single-class co-occurrence count unit: configuration
// registers, pixel loading, the two RAMs and the sequencer.
// Depends on scc_pkg, scc_ram and scc_seq.
//
// Usage:
//   A command transaction is taken at a clock edge with start high and busy
//   low. req_type selects: load next pixel (column-major), run a count pass
//   over the loaded raster, or read one class's presence and count.
//   Loads keep busy low, so pixels stream in one per cycle while no pass or
//   read holds busy high; loads past the clamped rows * cols are dropped.
//   A read keeps busy high in its wait state; its reply is then registered
//   and sits on the result ports for one cycle, marked by done.
//   A pass clears the class table, then walks the pixels: a missing one is
//   skipped, any other is marked seen, and each focal-class pixel reads its
//   in-bounds neighbor slots (4 or 8 slots) and bumps each non-missing
//   neighbor's class count, all bound by the single sequencer sharing one
//   pixel RAM read port and the table RAM ports; done is set from S_DONE.
//   done is a one-cycle strobe; the receiver cannot stall it.
//   Reset clears the configuration to 256 x 256, rook mode, focal class 0,
//   restarts loading at pixel 0 and makes reads return absent and zero until
//   the first pass. The pixel store is not cleared. The user, not the block,
//   makes configuration writes only while busy is low and no reply is pending.
`default_nettype none

module single_class_cooccurrence_count_unit import scc_pkg::*; #(
	parameter int MAX_SIDE     = MAX_SIDE_DEF,
	parameter int CLASS_VALUES = CLASS_VALUES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [REQ_W-1:0]      req_type,
	input  wire logic [CLASS_W-1:0]    pixel_class,
	input  wire logic                  pixel_missing,
	input  wire logic [CLASS_W-1:0]    query_class,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output logic                       done,
	output logic                       reply_kind,
	output logic [DISTINCT_W-1:0]      distinct_classes,
	output logic                       class_present,
	output logic [COUNT_W-1:0]         neighbor_count
);

	localparam int SW    = $clog2(MAX_SIDE + 1);
	localparam int AW    = $clog2(MAX_SIDE * MAX_SIDE);
	localparam int PW    = $clog2(MAX_SIDE * MAX_SIDE + 1);
	localparam int CW    = $clog2(CLASS_VALUES);
	localparam int EW    = COUNT_W + 1;
	localparam int TOT_W = 2 * SW;

	logic [SIZE_W-1:0]  raster_cols_q, raster_rows_q;
	logic               mode_q;
	logic [CLASS_W-1:0] focal_q;
	logic [PW-1:0]      load_pos_q;

	logic [SW-1:0]    cols_eff, rows_eff;
	logic [TOT_W-1:0] total;
	logic             accept, load_we, go_pass, go_read;

	logic [AW-1:0]    px_raddr;
	logic [PIX_W-1:0] px_rdata;
	logic [CW-1:0]    cnt_raddr, cnt_waddr;
	logic [EW-1:0]    cnt_rdata, cnt_wdata;
	logic             cnt_we;
	result_t          res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raster_cols_q <= 9'd256;
			raster_rows_q <= 9'd256;
			mode_q        <= 1'b0;
			focal_q       <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_COLS:  raster_cols_q <= cfg_wdata;
				CFG_ROWS:  raster_rows_q <= cfg_wdata;
				CFG_MODE:  mode_q        <= cfg_wdata[0];
				CFG_FOCAL: focal_q       <= cfg_wdata[CLASS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// clamp raster sides to 1..MAX_SIDE
	always_comb begin
		if (raster_cols_q == '0) begin
			cols_eff = SW'(1);
		end else if (32'(raster_cols_q) > MAX_SIDE) begin
			cols_eff = SW'(MAX_SIDE);
		end else begin
			cols_eff = SW'(raster_cols_q);
		end
		if (raster_rows_q == '0) begin
			rows_eff = SW'(1);
		end else if (32'(raster_rows_q) > MAX_SIDE) begin
			rows_eff = SW'(MAX_SIDE);
		end else begin
			rows_eff = SW'(raster_rows_q);
		end
	end

	// command decode
	assign total   = TOT_W'(cols_eff) * TOT_W'(rows_eff);
	assign accept  = start && !busy;
	assign load_we = accept && (req_type == REQ_LOAD) &&
	                 (32'(load_pos_q) < 32'(total));
	assign go_pass = accept && (req_type == REQ_PASS);
	assign go_read = accept && (req_type == REQ_READ);

	// load position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pos_q <= '0;
		end else if (load_we) begin
			load_pos_q <= load_pos_q + 1'b1;
		end
	end

	// pixel store: missing flag over class
	scc_ram #(
		.WIDTH(PIX_W),
		.DEPTH(MAX_SIDE * MAX_SIDE)
	) u_pixel_ram (
		.clk  (clk),
		.we   (load_we),
		.waddr(load_pos_q[AW-1:0]),
		.wdata({pixel_missing, pixel_class}),
		.raddr(px_raddr),
		.rdata(px_rdata)
	);

	// per-class table: seen flag over neighbor count
	scc_ram #(
		.WIDTH(EW),
		.DEPTH(CLASS_VALUES)
	) u_class_ram (
		.clk  (clk),
		.we   (cnt_we),
		.waddr(cnt_waddr),
		.wdata(cnt_wdata),
		.raddr(cnt_raddr),
		.rdata(cnt_rdata)
	);

	scc_seq #(
		.MAX_SIDE    (MAX_SIDE),
		.CLASS_VALUES(CLASS_VALUES)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.go_pass    (go_pass),
		.go_read    (go_read),
		.query_class(query_class),
		.cols_eff   (cols_eff),
		.rows_eff   (rows_eff),
		.mode       (mode_q),
		.focal      (focal_q),
		.px_raddr   (px_raddr),
		.px_rdata   (px_rdata),
		.cnt_raddr  (cnt_raddr),
		.cnt_rdata  (cnt_rdata),
		.cnt_we     (cnt_we),
		.cnt_waddr  (cnt_waddr),
		.cnt_wdata  (cnt_wdata),
		.busy       (busy),
		.res        (res)
	);

	// result ports
	assign done             = res.valid;
	assign reply_kind       = res.kind;
	assign distinct_classes = res.distinct;
	assign class_present    = res.present;
	assign neighbor_count   = res.count;

endmodule

`default_nettype wire

// File: test/tb_single_class_cooccurrence_count_unit.sv
// Self-checking testbench for single_class_cooccurrence_count_unit: drives load, pass and
// read command transactions, predicts every reply in place and checks each strobe.
// Depends on scc_pkg and the RTL of the unit; needs no files or arguments.
`timescale 1ns / 1ps

module tb_single_class_cooccurrence_count_unit;
	import scc_pkg::*;

	localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;   // unused code, ignored by the unit
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd5;   // index past the last register
	localparam int unsigned ITEM_TARGET = 1850;
	// worst pass: 256 entries cleared, ~2000 pixels walked, 8 neighbor slots per
	// focal pixel; the limit covers a few dozen such passes, with headroom
	localparam int unsigned CYCLE_LIMIT = 10_000_000;
	localparam int unsigned STORE_DEPTH = MAX_SIDE_DEF * MAX_SIDE_DEF;

	typedef struct packed {
		logic [REQ_W-1:0]   req;
		logic [CLASS_W-1:0] cls;
		logic               miss;
		logic [CLASS_W-1:0] qcls;
	} cmd_t;

	typedef struct packed {
		logic                  kind;
		logic [DISTINCT_W-1:0] distinct;
		logic                  present;
		logic [COUNT_W-1:0]    count;
	} reply_t;

	// DUT ports
	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [REQ_W-1:0]      req_type = REQ_LOAD;
	logic [CLASS_W-1:0]    pixel_class = '0;
	logic                  pixel_missing = 1'b0;
	logic [CLASS_W-1:0]    query_class = '0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_COLS;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  done;
	logic                  reply_kind;
	logic [DISTINCT_W-1:0] distinct_classes;
	logic                  class_present;
	logic [COUNT_W-1:0]    neighbor_count;

	single_class_cooccurrence_count_unit i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.req_type         (req_type),
		.pixel_class      (pixel_class),
		.pixel_missing    (pixel_missing),
		.query_class      (query_class),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.done             (done),
		.reply_kind       (reply_kind),
		.distinct_classes (distinct_classes),
		.class_present    (class_present),
		.neighbor_count   (neighbor_count)
	);

	// Predicted unit state
	logic [PIX_W-1:0]      pix_mem [0:STORE_DEPTH-1];
	logic [COUNT_W-1:0]    nbr_cnt [0:CLASS_VALUES_DEF-1];
	logic                  seen_cls [0:CLASS_VALUES_DEF-1];
	int unsigned           load_pos;
	logic [DISTINCT_W-1:0] n_distinct;
	logic [CFG_DATA_W-1:0] reg_cols;
	logic [CFG_DATA_W-1:0] reg_rows;
	logic                  reg_mode;
	logic [CLASS_W-1:0]    reg_focal;

	// Stimulus and scoreboard
	cmd_t               pending [$];
	reply_t             replies_due [$];
	logic [CLASS_W-1:0] palette [$];
	int unsigned        gap_left = 0;
	bit                 gap_free = 1'b0;
	int unsigned        issued = 0;
	int unsigned        mismatches = 0;
	int unsigned        cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		if (mismatches < 100)
			$display("ERROR at %0t: %s", $time, what);
		mismatches++;
	endtask

	// Size registers: 0 acts as 1, anything past the store side acts as the side
	function automatic int unsigned eff_side(input logic [CFG_DATA_W-1:0] raw);
		if (raw == 0)
			return 1;
		if (raw > MAX_SIDE_DEF)
			return MAX_SIDE_DEF;
		return 32'(raw);
	endfunction

	// Full walk of the raster: class presence, distinct total, focal neighbor tally
	function automatic void run_count_pass();
		int nc, nr, c, r, dc, dr, xc, xr, k;
		logic [PIX_W-1:0] p, q;
		nc = eff_side(reg_cols);
		nr = eff_side(reg_rows);
		for (k = 0; k < CLASS_VALUES_DEF; k++) begin
			nbr_cnt[k] = '0;
			seen_cls[k] = 1'b0;
		end
		n_distinct = '0;
		for (c = 0; c < nc; c++) begin
			for (r = 0; r < nr; r++) begin
				p = pix_mem[c * nr + r];
				if (p[CLASS_W])
					continue;
				if (!seen_cls[p[CLASS_W-1:0]]) begin
					seen_cls[p[CLASS_W-1:0]] = 1'b1;
					if (n_distinct != DISTINCT_MAX)
						n_distinct++;
				end
				if (p[CLASS_W-1:0] != reg_focal)
					continue;
				for (dc = -1; dc <= 1; dc++) begin
					for (dr = -1; dr <= 1; dr++) begin
						// rook mode drops the diagonals
						if ((dc == 0 && dr == 0) || (!reg_mode && dc != 0 && dr != 0))
							continue;
						xc = c + dc;
						xr = r + dr;
						if (xc < 0 || xr < 0 || xc >= nc || xr >= nr)
							continue;
						q = pix_mem[xc * nr + xr];
						if (q[CLASS_W])
							continue;
						if (nbr_cnt[q[CLASS_W-1:0]] != COUNT_MAX)
							nbr_cnt[q[CLASS_W-1:0]]++;
					end
				end
			end
		end
	endfunction

	// Advance the predicted state by one command; returns 1 when a reply is due
	function automatic bit apply_command(input cmd_t cmd, output reply_t rep);
		bit has_reply;
		has_reply = 1'b0;
		rep = '0;
		case (cmd.req)
			REQ_LOAD: begin
				// loads past the raster are dropped
				if (load_pos < eff_side(reg_cols) * eff_side(reg_rows)) begin
					pix_mem[load_pos] = {cmd.miss, cmd.cls};
					load_pos++;
				end
			end
			REQ_PASS: begin
				run_count_pass();
				rep.kind = REPLY_PASS;
				rep.distinct = n_distinct;
				has_reply = 1'b1;
			end
			REQ_READ: begin
				rep.kind = REPLY_READ;
				rep.distinct = n_distinct;
				rep.present = seen_cls[cmd.qcls];
				rep.count = nbr_cnt[cmd.qcls];
				has_reply = 1'b1;
			end
			default: ;
		endcase
		return has_reply;
	endfunction

	function automatic int unsigned next_gap();
		int unsigned roll;
		if (gap_free)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(13, 40);
	endfunction

	// Command driver: holds start until the unit takes the transaction
	always @(posedge clk) begin : cmd_driver
		cmd_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!start || !busy) begin
			if (gap_left != 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending.size() != 0) begin
				nxt = pending.pop_front();
				req_type <= nxt.req;
				pixel_class <= nxt.cls;
				pixel_missing <= nxt.miss;
				query_class <= nxt.qcls;
				start <= 1'b1;
				gap_left = next_gap();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: predicts on each accepted command, checks each reply strobe
	always @(posedge clk) begin : reply_monitor
		cmd_t taken;
		reply_t pred, head;
		if (arst_n) begin
			if (start && !busy) begin
				taken.req = req_type;
				taken.cls = pixel_class;
				taken.miss = pixel_missing;
				taken.qcls = query_class;
				if (apply_command(taken, pred))
					replies_due.insert(replies_due.size(), pred);
			end
			if (done) begin
				if (replies_due.size() == 0) begin
					report_mismatch("reply strobe with no reply outstanding");
				end else begin
					head = replies_due.pop_front();
					if (reply_kind !== head.kind)
						report_mismatch($sformatf("reply_kind %0b, want %0b",
							reply_kind, head.kind));
					if (distinct_classes !== head.distinct)
						report_mismatch($sformatf("distinct_classes %0d, want %0d",
							distinct_classes, head.distinct));
					if (class_present !== head.present)
						report_mismatch($sformatf("class_present %0b, want %0b",
							class_present, head.present));
					if (neighbor_count !== head.count)
						report_mismatch($sformatf("neighbor_count %0d, want %0d",
							neighbor_count, head.count));
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("single_class_cooccurrence_count_unit: mismatch");
			$finish;
		end
	end

	task automatic queue_cmd(input logic [REQ_W-1:0] req, input logic [CLASS_W-1:0] cls,
			input logic miss, input logic [CLASS_W-1:0] qcls);
		cmd_t c;
		c.req = req;
		c.cls = cls;
		c.miss = miss;
		c.qcls = qcls;
		pending.insert(pending.size(), c);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_COLS:  reg_cols = val;
			CFG_ROWS:  reg_rows = val;
			CFG_MODE:  reg_mode = val[0];
			CFG_FOCAL: reg_focal = val[CLASS_W-1:0];
			default: ;
		endcase
	endtask

	// Everything sent, every reply in, unit quiet; then a short settle
	task automatic wait_idle();
		@(negedge clk);
		while (pending.size() != 0 || start || busy || replies_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [CLASS_W-1:0] pick_pixel();
		if ($urandom_range(0, 4) == 0)
			return CLASS_W'($urandom_range(0, 255));
		return palette[$urandom_range(0, palette.size() - 1)];
	endfunction

	function automatic logic [CLASS_W-1:0] pick_query(input logic [CLASS_W-1:0] foc);
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll < 5)
			return palette[$urandom_range(0, palette.size() - 1)];
		if (roll < 7)
			return foc;
		return CLASS_W'($urandom_range(0, 255));
	endfunction

	// One random setting: new geometry and focal class, fresh pixels, passes, reads
	task automatic random_phase();
		int unsigned pos, cap, target, total, fresh, npass, k, j;
		logic [CFG_DATA_W-1:0] cols_raw, rows_raw;
		logic [CLASS_W-1:0] foc;
		pos = load_pos;
		case ($urandom_range(0, 9))
			0: begin
				// one row as wide as the store, register at or past the side
				cols_raw = CFG_DATA_W'($urandom_range(256, 511));
				rows_raw = CFG_DATA_W'($urandom_range(0, 1));
			end
			1: begin
				rows_raw = CFG_DATA_W'($urandom_range(256, 511));
				cols_raw = CFG_DATA_W'($urandom_range(0, 1));
			end
			2, 3: begin
				// reshape pixels already stored, no new loads land
				cap = (pos < 16) ? pos : 16;
				cols_raw = CFG_DATA_W'($urandom_range(1, cap));
				cap = pos / cols_raw;
				if (cap > MAX_SIDE_DEF)
					cap = MAX_SIDE_DEF;
				rows_raw = CFG_DATA_W'($urandom_range(1, cap));
			end
			default: begin
				target = pos + $urandom_range(4, 120);
				cols_raw = CFG_DATA_W'($urandom_range(1, 24));
				cap = (target + cols_raw - 1) / cols_raw;
				if (cap > MAX_SIDE_DEF)
					cap = MAX_SIDE_DEF;
				rows_raw = CFG_DATA_W'(cap);
			end
		endcase

		palette.delete();
		repeat ($urandom_range(2, 6))
			palette.insert(palette.size(), CLASS_W'($urandom_range(0, 255)));
		foc = ($urandom_range(0, 7) == 0) ? CLASS_W'($urandom_range(0, 255)) : palette[0];
		gap_free = ($urandom_range(0, 3) == 0);

		write_reg(CFG_COLS, cols_raw);
		write_reg(CFG_ROWS, rows_raw);
		write_reg(CFG_MODE, CFG_DATA_W'($urandom_range(0, 1)));
		write_reg(CFG_FOCAL, CFG_DATA_W'(foc));
		if ($urandom_range(0, 3) == 0)
			write_reg(CFG_IDX_W'($urandom_range(4, 7)), CFG_DATA_W'($urandom_range(0, 511)));
		@(negedge clk);

		total = eff_side(cols_raw) * eff_side(rows_raw);
		fresh = (total > pos) ? total - pos : 0;
		for (k = 0; k < fresh; k++) begin
			j = $urandom_range(0, 59);
			if (j == 0) begin
				queue_cmd(REQ_SPARE, CLASS_W'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), CLASS_W'($urandom_range(0, 255)));
			end else if (j < 3) begin
				queue_cmd(REQ_READ, CLASS_W'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), pick_query(foc));
				issued++;
			end
			queue_cmd(REQ_LOAD, pick_pixel(), ($urandom_range(0, 7) == 0),
				CLASS_W'($urandom_range(0, 255)));
			issued++;
		end
		// loads past the end of the raster
		repeat ($urandom_range(0, 2))
			queue_cmd(REQ_LOAD, CLASS_W'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)), CLASS_W'($urandom_range(0, 255)));

		npass = ($urandom_range(0, 3) == 0) ? 2 : 1;
		repeat (npass) begin
			queue_cmd(REQ_PASS, CLASS_W'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)), CLASS_W'($urandom_range(0, 255)));
			issued++;
			repeat ($urandom_range(2, 8)) begin
				queue_cmd(REQ_READ, CLASS_W'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), pick_query(foc));
				issued++;
			end
		end
		wait_idle();
	endtask

	initial begin : stimulus
		int k;
		// predicted reset state; the pixel store stays unknown until loaded
		for (k = 0; k < CLASS_VALUES_DEF; k++) begin
			nbr_cnt[k] = '0;
			seen_cls[k] = 1'b0;
		end
		load_pos = 0;
		n_distinct = '0;
		reg_cols = 9'd256;
		reg_rows = 9'd256;
		reg_mode = 1'b0;
		reg_focal = '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reads before any pass see an empty table; spare code is ignored
		queue_cmd(REQ_READ, 8'h00, 1'b0, 8'h00);
		queue_cmd(REQ_READ, 8'hFF, 1'b1, 8'hFF);
		queue_cmd(REQ_SPARE, 8'hFF, 1'b1, 8'hAA);
		issued += 2;
		wait_idle();

		// 3x3 raster, focal 255 at a corner and the center, missing pixels,
		// a missing focal pixel, class extremes
		write_reg(CFG_COLS, 9'd3);
		write_reg(CFG_ROWS, 9'd3);
		write_reg(CFG_MODE, 9'd0);
		write_reg(CFG_FOCAL, 9'd255);
		write_reg(CFG_SPARE, 9'h1FF);
		@(negedge clk);
		queue_cmd(REQ_LOAD, 8'd255, 1'b0, 8'h00);
		queue_cmd(REQ_LOAD, 8'd0,   1'b0, 8'hFF);
		queue_cmd(REQ_LOAD, 8'd7,   1'b1, 8'h00);
		queue_cmd(REQ_LOAD, 8'd0,   1'b0, 8'h00);
		queue_cmd(REQ_LOAD, 8'd255, 1'b0, 8'h00);
		queue_cmd(REQ_LOAD, 8'd128, 1'b0, 8'h00);
		queue_cmd(REQ_LOAD, 8'd255, 1'b1, 8'h00);
		queue_cmd(REQ_LOAD, 8'd1,   1'b0, 8'h00);
		queue_cmd(REQ_LOAD, 8'd0,   1'b0, 8'h00);
		queue_cmd(REQ_LOAD, 8'd9,   1'b0, 8'h00);   // past the raster, dropped
		queue_cmd(REQ_PASS, 8'h00,  1'b0, 8'h00);
		queue_cmd(REQ_READ, 8'h00,  1'b0, 8'd0);
		queue_cmd(REQ_READ, 8'h00,  1'b0, 8'd255);
		queue_cmd(REQ_READ, 8'h00,  1'b0, 8'd128);
		queue_cmd(REQ_READ, 8'h00,  1'b0, 8'd7);
		issued += 14;
		wait_idle();

		// same raster, queen neighbors
		write_reg(CFG_MODE, 9'd1);
		@(negedge clk);
		queue_cmd(REQ_PASS, 8'h00, 1'b0, 8'h00);
		queue_cmd(REQ_READ, 8'h00, 1'b0, 8'd0);
		queue_cmd(REQ_READ, 8'h00, 1'b0, 8'd1);
		issued += 3;
		wait_idle();

		// zero columns acts as one; focal class absent leaves all counts zero
		write_reg(CFG_COLS, 9'd0);
		write_reg(CFG_ROWS, 9'd9);
		write_reg(CFG_MODE, 9'd0);
		write_reg(CFG_FOCAL, 9'd200);
		@(negedge clk);
		queue_cmd(REQ_PASS, 8'h00, 1'b0, 8'h00);
		queue_cmd(REQ_READ, 8'h00, 1'b0, 8'd0);
		queue_cmd(REQ_READ, 8'h00, 1'b0, 8'd200);
		issued += 3;
		wait_idle();

		while (issued < ITEM_TARGET)
			random_phase();

		wait_idle();
		repeat (8) @(negedge clk);
		if (replies_due.size() != 0)
			report_mismatch($sformatf("%0d replies never arrived", replies_due.size()));
		if (mismatches == 0)
			$display("single_class_cooccurrence_count_unit: match");
		else
			$display("single_class_cooccurrence_count_unit: mismatch");
		$finish;
	end

endmodule
